@@ rtl/ptpre_pkg.sv @@
// shared types and constants for the pixel threshold / pack / run-length encoder
// used by every rtl module of the block; depends on nothing
`default_nettype none

package ptpre_pkg;

  // channel and byte widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned SumW    = 10;
  localparam int unsigned BitCntW = 3;

  // configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 2;
  localparam logic [CfgIdxW-1:0] REG_MODE   = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_INVERT = 1'd1;

  // encoding modes
  localparam logic [1:0] MODE_RAW  = 2'd0;
  localparam logic [1:0] MODE_PACK = 2'd1;
  localparam logic [1:0] MODE_RUN  = 2'd2;

  // threshold and run cap
  localparam logic [SumW-1:0]  BRIGHT_LIMIT = 10'd384;
  localparam logic [ByteW-1:0] RUN_MAX      = 8'd255;

  // bytes a single pixel can produce
  localparam int unsigned MaxBytes = 3;
  localparam int unsigned NumW     = 2;

  // default depth of the command queue
  localparam int unsigned QUEUE_DEPTH = 2;

  // one pixel's worth of output bytes, slot 0 goes out first
  typedef struct packed {
    logic [NumW-1:0]                num;
    logic [MaxBytes-1:0][ByteW-1:0] data;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/pixel_threshold_pack_rle_encoder_top.sv @@
// Pixel encoder: one RGB pixel in per request, encoded bytes out one per request.
// Mode 0 sends red, green and blue (3 bytes per pixel); mode 1 packs a bright bit
// per pixel LSB first and mode 2 sends dark run lengths, both taking one pixel per
// cycle while the command queue has room. The byte-wide output port sets the
// sustained rate; with an empty queue the first byte of a pixel is offered the
// cycle after the pixel is accepted, later when earlier bytes are still queued.
// Configuration must be written while idle; the block does not enforce this.
// Top level; depends on ptpre_pkg, ptpre_front, ptpre_queue, ptpre_back
`default_nettype none

module pixel_threshold_pack_rle_encoder_top #(
  parameter int unsigned QueueDepth = ptpre_pkg::QUEUE_DEPTH
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [ptpre_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [ptpre_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [ptpre_pkg::ByteW-1:0]      red_i,
  input  wire logic [ptpre_pkg::ByteW-1:0]      green_i,
  input  wire logic [ptpre_pkg::ByteW-1:0]      blue_i,
  input  wire logic                             end_of_image_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [ptpre_pkg::ByteW-1:0]           byte_out_o,
  output logic                                  last_of_item_o
);

  logic            push, full, q_valid, pop;
  ptpre_pkg::cmd_t cmd, head;

  // classify pixel and build its byte command
  ptpre_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .end_of_image_i (end_of_image_i),
    .push_o         (push),
    .cmd_o          (cmd),
    .full_i         (full)
  );

  // decoupling queue
  ptpre_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .full_o  (full),
    .valid_o (q_valid),
    .head_o  (head),
    .pop_i   (pop)
  );

  // byte serializer
  ptpre_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .byte_out_o     (byte_out_o),
    .last_of_item_o (last_of_item_o)
  );

endmodule

`default_nettype wire

@@ rtl/ptpre_front.sv @@
// front end: config registers, pixel classification and encoder state
// produces one command of up to three bytes per pixel; depends on ptpre_pkg
`default_nettype none

module ptpre_front (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [ptpre_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [ptpre_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [ptpre_pkg::ByteW-1:0]        red_i,
  input  wire logic [ptpre_pkg::ByteW-1:0]        green_i,
  input  wire logic [ptpre_pkg::ByteW-1:0]        blue_i,
  input  wire logic                               end_of_image_i,
  output logic                                    push_o,
  output ptpre_pkg::cmd_t                         cmd_o,
  input  wire logic                               full_i
);

  logic [1:0]                       mode_q;
  logic                             invert_q;
  logic [ptpre_pkg::ByteW-1:0]      bit_accum_q, bit_accum_d;
  logic [ptpre_pkg::BitCntW-1:0]    bit_count_q, bit_count_d;
  logic [ptpre_pkg::ByteW-1:0]      run_count_q, run_count_d;

  logic                             accept;
  logic [ptpre_pkg::ByteW-1:0]      r, g, b;
  logic [ptpre_pkg::SumW-1:0]       sum;
  logic                             bright;
  logic [ptpre_pkg::ByteW-1:0]      acc_set;
  logic [ptpre_pkg::BitCntW-1:0]    cnt_inc;
  logic [ptpre_pkg::ByteW-1:0]      run_inc;

  assign in_ready_o = ~full_i;
  assign accept     = in_valid_i & in_ready_o;

  // optional inversion and brightness test
  assign r      = invert_q ? ~red_i   : red_i;
  assign g      = invert_q ? ~green_i : green_i;
  assign b      = invert_q ? ~blue_i  : blue_i;
  assign sum    = ptpre_pkg::SumW'(r) + ptpre_pkg::SumW'(g) + ptpre_pkg::SumW'(b);
  assign bright = (sum >= ptpre_pkg::BRIGHT_LIMIT);

  assign acc_set = bit_accum_q | (ptpre_pkg::ByteW'(bright) << bit_count_q);
  assign cnt_inc = bit_count_q + ptpre_pkg::BitCntW'(1);
  assign run_inc = run_count_q + ptpre_pkg::ByteW'(1);

  // per-mode byte generation and state update
  always_comb begin
    cmd_o       = '0;
    bit_accum_d = bit_accum_q;
    bit_count_d = bit_count_q;
    run_count_d = run_count_q;
    case (mode_q)
      ptpre_pkg::MODE_RAW: begin
        cmd_o.num     = 2'd3;
        cmd_o.data[0] = r;
        cmd_o.data[1] = g;
        cmd_o.data[2] = b;
      end
      ptpre_pkg::MODE_PACK: begin
        bit_count_d = cnt_inc;
        if (cnt_inc == '0) begin
          // byte complete
          cmd_o.num     = 2'd1;
          cmd_o.data[0] = acc_set;
          bit_accum_d   = '0;
        end else begin
          bit_accum_d = acc_set;
          if (end_of_image_i) begin
            // flush the partial byte
            cmd_o.num     = 2'd1;
            cmd_o.data[0] = acc_set;
          end
        end
      end
      ptpre_pkg::MODE_RUN: begin
        if (bright) begin
          run_count_d = '0;
          if (run_count_q != '0) begin
            cmd_o.num     = 2'd2;
            cmd_o.data[0] = run_count_q;
            cmd_o.data[1] = '0;
          end else begin
            cmd_o.num     = 2'd1;
            cmd_o.data[0] = '0;
          end
        end else if (run_count_q == ptpre_pkg::RUN_MAX) begin
          // capped run goes out, new run starts at one
          run_count_d   = ptpre_pkg::ByteW'(1);
          cmd_o.data[0] = ptpre_pkg::RUN_MAX;
          cmd_o.data[1] = ptpre_pkg::ByteW'(1);
          cmd_o.num     = end_of_image_i ? 2'd2 : 2'd1;
        end else begin
          run_count_d   = run_inc;
          cmd_o.data[0] = run_inc;
          cmd_o.num     = end_of_image_i ? 2'd1 : 2'd0;
        end
      end
      default: begin
        cmd_o.num = 2'd0;
      end
    endcase
    if (end_of_image_i) begin
      bit_accum_d = '0;
      bit_count_d = '0;
      run_count_d = '0;
    end
  end

  assign push_o = accept & (cmd_o.num != '0);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ptpre_pkg::MODE_RAW;
      invert_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ptpre_pkg::REG_MODE:   mode_q   <= cfg_wdata_i;
        ptpre_pkg::REG_INVERT: invert_q <= cfg_wdata_i[0];
        default:               mode_q   <= mode_q;
      endcase
    end
  end

  // encoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_accum_q <= '0;
      bit_count_q <= '0;
      run_count_q <= '0;
    end else if (accept) begin
      bit_accum_q <= bit_accum_d;
      bit_count_q <= bit_count_d;
      run_count_q <= run_count_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ptpre_queue.sv @@
// short command queue between front and back ends
// register based, Depth entries; depends on ptpre_pkg
`default_nettype none

module ptpre_queue #(
  parameter int unsigned Depth = ptpre_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire ptpre_pkg::cmd_t  cmd_i,
  output logic                  full_o,
  output logic                  valid_o,
  output ptpre_pkg::cmd_t       head_o,
  input  wire logic             pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ptpre_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ptpre_back.sv @@
// back end: serializes one queued command into bytes, one per cycle while a command is queued and out_ready_i is high
// marks the last byte of each pixel; depends on ptpre_pkg
`default_nettype none

module ptpre_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  input  wire ptpre_pkg::cmd_t              head_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [ptpre_pkg::ByteW-1:0]       byte_out_o,
  output logic                              last_of_item_o
);

  logic [ptpre_pkg::NumW-1:0] idx_q, idx_d;
  logic                       take;

  assign out_valid_o    = valid_i;
  assign byte_out_o     = head_i.data[idx_q];
  assign last_of_item_o = (idx_q == head_i.num - ptpre_pkg::NumW'(1));
  assign take           = valid_i & out_ready_i;
  assign pop_o          = take & last_of_item_o;

  // byte slot within the current command
  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = last_of_item_o ? '0 : idx_q + ptpre_pkg::NumW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ptpre_checker.sv @@
// port-level checks for the pixel encoder top level
// bound to pixel_threshold_pack_rle_encoder_top; depends on ptpre_pkg
`default_nettype none

module ptpre_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire logic [ptpre_pkg::ByteW-1:0]    byte_out_o,
  input wire logic                           last_of_item_o
);

  default clocking cb @(posedge clk_i); endclocking

  // a stalled byte holds
  assert property (disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(byte_out_o)
      && $stable(last_of_item_o))
    else $error("stalled output byte changed");

  // input is only held off while bytes are pending
  assert property (disable iff (!rst_ni) !in_ready_o |-> out_valid_o)
    else $error("input stalled with nothing to send");

  // remaining bytes of a pixel follow right away
  assert property (disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_item_o |=> out_valid_o)
    else $error("pixel bytes broken off before last byte");

  // output only appears after a pixel request
  assert property (disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("output appeared without an input request");

endmodule

bind pixel_threshold_pack_rle_encoder_top ptpre_checker u_ptpre_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .byte_out_o     (byte_out_o),
  .last_of_item_o (last_of_item_o)
);

`default_nettype wire
